### src/gbp_pkg.sv
// Shared types, constants and helpers for the gshare branch predictor.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package gbp_pkg;

  // 2-bit saturating direction counter
  typedef logic [1:0] ctr_t;
  localparam ctr_t CTR_MIN   = 2'd0;
  localparam ctr_t CTR_RESET = 2'd2;  // weakly taken
  localparam ctr_t CTR_MAX   = 2'd3;

  // History length register
  typedef logic [3:0] hlen_t;
  localparam hlen_t HLEN_RESET = 4'd12;

  // Branch address and running totals
  typedef logic [31:0] baddr_t;
  typedef logic [31:0] total_t;
  localparam total_t TOTAL_MAX = 32'hFFFF_FFFF;

  // Move a counter one step towards the resolved direction
  function automatic ctr_t ctr_next(ctr_t c, logic tk);
    ctr_t r;
    r = c;
    if (tk) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

  // Saturating increment of a total
  function automatic total_t total_inc(total_t v);
    return (v == TOTAL_MAX) ? v : v + 32'd1;
  endfunction

endpackage

`default_nettype wire

### src/gbp_if.sv
// Channel interfaces of the gshare branch predictor: branch input, result
// output and history length configuration. Depends on gbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Resolved branch channel
interface gbp_in_if;
  logic            valid;
  logic            ready;
  gbp_pkg::baddr_t branch_addr;
  logic            taken;
  modport source (output valid, output branch_addr, output taken, input ready);
  modport sink   (input valid, input branch_addr, input taken, output ready);
endinterface

// Prediction result channel
interface gbp_out_if;
  logic            valid;
  logic            ready;
  logic            predicted_taken;
  logic            mispredicted;
  gbp_pkg::total_t hit_total;
  gbp_pkg::total_t miss_total;
  modport source (output valid, output predicted_taken, output mispredicted,
                  output hit_total, output miss_total, input ready);
  modport sink   (input valid, input predicted_taken, input mispredicted,
                  input hit_total, input miss_total, output ready);
endinterface

// History length write channel
interface gbp_cfg_if;
  logic           valid;
  logic           ready;
  gbp_pkg::hlen_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/gbp_hist.sv
// History length register, global history register and gshare index hash.
// Depends on gbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbp_hist #(
  parameter int INDEX_BITS = 12
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_we,
  input  gbp_pkg::hlen_t          cfg_data,
  input  wire                     acc,
  input  wire  [INDEX_BITS-1:0]   addr_bits,
  input  wire                     taken,
  output logic [INDEX_BITS-1:0]   idx
);

  // History never exceeds the 4-bit length register's range
  localparam int HIST_W = (INDEX_BITS < 15) ? INDEX_BITS : 15;
  localparam int SH_W   = $clog2(INDEX_BITS + 1);
  localparam gbp_pkg::hlen_t H_CAP = gbp_pkg::hlen_t'(HIST_W);

  gbp_pkg::hlen_t    hlen_r;
  logic [HIST_W-1:0] hist_r, hist_nxt;
  gbp_pkg::hlen_t    h;
  logic [HIST_W-1:0] mask, hist_m, ins;
  logic [SH_W-1:0]   shamt;
  logic [INDEX_BITS-1:0] shifted;

  // Effective length, clipped to the index width
  assign h      = (hlen_r > H_CAP) ? H_CAP : hlen_r;
  assign mask   = ~({HIST_W{1'b1}} << h);
  assign hist_m = hist_r & mask;

  // Index: address bits XOR history aligned to the top of the index
  assign shamt   = SH_W'(INDEX_BITS) - SH_W'(h);
  assign shifted = INDEX_BITS'(hist_m) << shamt;
  assign idx     = addr_bits ^ shifted;

  // Outcome enters at bit h-1, older bits move down
  always_comb begin
    ins = '0;
    if (h != 4'd0 && taken) ins = HIST_W'(1) << (h - 4'd1);
    hist_nxt = ((hist_m >> 1) | ins) & mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hlen_r <= gbp_pkg::HLEN_RESET;
      hist_r <= '0;
    end else begin
      if (cfg_we) hlen_r <= cfg_data;
      if (acc)    hist_r <= hist_nxt;
    end
  end

endmodule

`default_nettype wire

### src/gbp_table.sv
// Counter table: single-port-write RAM with registered read, clearing pass
// after reset and write-to-read forwarding. Depends on gbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbp_table #(
  parameter int INDEX_BITS = 12
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    rd_en,
  input  wire  [INDEX_BITS-1:0]  rd_idx,
  output gbp_pkg::ctr_t          rd_ctr,
  input  wire                    wr_en,
  input  wire  [INDEX_BITS-1:0]  wr_idx,
  input  gbp_pkg::ctr_t          wr_ctr,
  output logic                   busy
);

  localparam int DEPTH = 1 << INDEX_BITS;

  gbp_pkg::ctr_t mem [DEPTH];
  gbp_pkg::ctr_t q_r;
  logic          fwd_hit_r;
  gbp_pkg::ctr_t fwd_ctr_r;
  logic          clr_r;
  logic [INDEX_BITS-1:0] clr_addr_r;

  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_wa;
  gbp_pkg::ctr_t         mem_wd;

  // Clearing pass owns the write port until it finishes
  assign mem_we = clr_r | wr_en;
  assign mem_wa = clr_r ? clr_addr_r : wr_idx;
  assign mem_wd = clr_r ? gbp_pkg::CTR_RESET : wr_ctr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en)  q_r <= mem[rd_idx];
  end

  // A write at the same edge as the read is missed by the RAM: bypass it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= wr_en && (wr_idx == rd_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) fwd_ctr_r <= wr_ctr;
  end

  assign rd_ctr = fwd_hit_r ? fwd_ctr_r : q_r;

  // One entry per cycle back to weakly taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == {INDEX_BITS{1'b1}}) clr_r <= 1'b0;
    end
  end

  assign busy = clr_r;

endmodule

`default_nettype wire

### src/gbp_eval.sv
// Evaluate stage: prediction, counter update, running totals and the
// result register. Depends on gbp_pkg and gbp_if.
`timescale 1ns / 1ps
`default_nettype none

module gbp_eval #(
  parameter int INDEX_BITS = 12
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    acc,
  input  wire  [INDEX_BITS-1:0]  acc_idx,
  input  wire                    acc_taken,
  input  gbp_pkg::ctr_t          ctr,
  output logic                   s1_free,
  output logic                   wr_en,
  output logic [INDEX_BITS-1:0]  wr_idx,
  output gbp_pkg::ctr_t          wr_ctr,
  gbp_out_if.source              out_ch
);

  logic                  s1_valid_r;
  logic [INDEX_BITS-1:0] s1_idx_r;
  logic                  s1_tk_r;
  logic                  out_valid_r;
  logic                  out_pred_r, out_miss_r;
  gbp_pkg::total_t       hit_r, miss_r;
  logic                  adv, pred, miss;

  // Stage moves on when the result register is empty or being drained
  assign adv     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign s1_free = !s1_valid_r || adv;

  assign pred = (ctr >= gbp_pkg::CTR_RESET);
  assign miss = pred ^ s1_tk_r;

  // Counter write-back happens as the transaction leaves the stage
  assign wr_en  = adv;
  assign wr_idx = s1_idx_r;
  assign wr_ctr = gbp_pkg::ctr_next(ctr, s1_tk_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_idx_r <= acc_idx;
      s1_tk_r  <= acc_taken;
    end
  end

  // Result valid flag and totals; the totals only change when a new result is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hit_r       <= '0;
      miss_r      <= '0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
        if (miss) miss_r <= gbp_pkg::total_inc(miss_r);
        else      hit_r  <= gbp_pkg::total_inc(hit_r);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pred_r <= pred;
      out_miss_r <= miss;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.predicted_taken = out_pred_r;
  assign out_ch.mispredicted    = out_miss_r;
  assign out_ch.hit_total       = hit_r;
  assign out_ch.miss_total      = miss_r;

endmodule

`default_nettype wire

### src/gshare_branch_predictor_unit.sv
// Top level of the gshare branch predictor: joins history, counter table
// and evaluate stage. Depends on gbp_pkg, gbp_if, gbp_hist, gbp_table, gbp_eval.
`timescale 1ns / 1ps
`default_nettype none

// Gshare predictor taking one resolved branch per clock unless stalled. The
// index is the address bits [INDEX_BITS+1:2] XOR the global history aligned
// to the top of the index; the history updates as the transaction is accepted.
// The counter table is a RAM with registered read: a transaction is accepted,
// its counter is read at that edge, then evaluated and written back as it
// leaves the evaluate stage, with a bypass for a write to the same entry at
// the read edge. Sustained rate is one transaction per cycle while results
// are drained; a result passes the evaluate stage register and then the
// result register, and a stalled result register holds back the stage. After
// reset a clearing pass sets all 2^INDEX_BITS counters to weakly taken; in_ch.ready
// stays low during it while history length writes are taken at any time.
module gshare_branch_predictor_unit #(
  parameter int INDEX_BITS = 12
) (
  input  wire        clk,
  input  wire        rst_n,
  gbp_in_if.sink     in_ch,
  gbp_out_if.source  out_ch,
  gbp_cfg_if.sink    cfg_ch
);

  logic                  acc, busy, s1_free, wr_en;
  logic [INDEX_BITS-1:0] idx, wr_idx;
  gbp_pkg::ctr_t         rd_ctr, wr_ctr;

  // Input handshake
  assign in_ch.ready  = !busy && s1_free;
  assign acc          = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  gbp_hist #(.INDEX_BITS(INDEX_BITS)) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.data),
    .acc       (acc),
    .addr_bits (in_ch.branch_addr[INDEX_BITS+1:2]),
    .taken     (in_ch.taken),
    .idx       (idx)
  );

  gbp_table #(.INDEX_BITS(INDEX_BITS)) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (acc),
    .rd_idx (idx),
    .rd_ctr (rd_ctr),
    .wr_en  (wr_en),
    .wr_idx (wr_idx),
    .wr_ctr (wr_ctr),
    .busy   (busy)
  );

  gbp_eval #(.INDEX_BITS(INDEX_BITS)) u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .acc_idx   (idx),
    .acc_taken (in_ch.taken),
    .ctr       (rd_ctr),
    .s1_free   (s1_free),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_ctr    (wr_ctr),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
